FILE: rtl/core/peq_pkg.sv
`default_nettype none

package peq_pkg;

  localparam int CHANNELS_DEFAULT = 8;

  localparam int SAMPLE_W  = 24;
  localparam int CH_W      = 3;
  localparam int COEF_W    = 32;
  localparam int RAMP_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int PROD_W    = 2 * COEF_W;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_START = 3'd0,
    REG_B_START = 3'd1,
    REG_G_START = 3'd2,
    REG_A_STEP  = 3'd3,
    REG_B_STEP  = 3'd4,
    REG_G_STEP  = 3'd5,
    REG_RAMP    = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BZ2,
    ST_AZ1,
    ST_BY1,
    ST_AY2,
    ST_GT,
    ST_RES,
    ST_OUT
  } seq_state_t;

  // one channel's lattice states as kept in the state memory
  typedef struct packed {
    coef_t near_val;
    coef_t far_val;
  } state_pair_t;

  function automatic coef_t qadd(input coef_t a, input coef_t b);
    logic signed [COEF_W:0] s;
    s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
    if (s[COEF_W] != s[COEF_W-1]) begin
      return s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end
    return s[COEF_W-1:0];
  endfunction

  function automatic coef_t qsub(input coef_t a, input coef_t b);
    logic signed [COEF_W:0] s;
    s = {a[COEF_W-1], a} - {b[COEF_W-1], b};
    if (s[COEF_W] != s[COEF_W-1]) begin
      return s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end
    return s[COEF_W-1:0];
  endfunction

  // Q8.56 product back to Q4.28: round half up, then saturate
  function automatic coef_t round_q28(input prod_t p);
    prod_t s;
    s = p + 64'sd134217728;
    s = s >>> 28;
    if (s > 64'sd2147483647) begin
      return {1'b0, {(COEF_W-1){1'b1}}};
    end
    if (s < -64'sd2147483648) begin
      return {1'b1, {(COEF_W-1){1'b0}}};
    end
    return s[COEF_W-1:0];
  endfunction

  // Q4.28 to Q1.23 with rounding and saturation
  function automatic sample_t to_sample(input coef_t v);
    logic signed [COEF_W:0] s;
    s = {v[COEF_W-1], v} + 33'sd16;
    s = s >>> 5;
    if (s > 33'sd8388607) begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    if (s < -33'sd8388608) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end
    return s[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/peq_state_mem.sv
`default_nettype none

module peq_state_mem
  import peq_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT,
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output state_pair_t      rd_data,
  input  wire logic        wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire state_pair_t wr_data
);

  state_pair_t         mem [CHANNELS];
  logic [CHANNELS-1:0] written;
  state_pair_t         mem_q;
  logic                written_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // entries not yet written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        written_q <= written[rd_addr];
      end
    end
  end

  assign rd_data = written_q ? mem_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/parametric_eq_section_top.sv
// From an accepted word to sample_out valid: accept, state read, five multiplies on one shared
// 32x32 multiplier, final subtract; a channel >= CHANNELS goes straight to the output.
// Words are taken one at a time, as set by the single multiplier and the read-modify-write of the
// per-channel state memory; a new word is taken while a result waits.
// Reset (rst, synchronous): lattice states read as zero, coefficients, steps and ramp clear.
`default_nettype none

module parametric_eq_section_top
  import peq_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [SAMPLE_W-1:0]  sample_in,
  input  wire logic [CH_W-1:0]      channel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [SAMPLE_W-1:0]       sample_out,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [AW+CH_W-1:0] CH_LIMIT = (AW + CH_W)'(CHANNELS);

  seq_state_t state, state_next;

  coef_t coef_a, coef_b, gain_term;
  coef_t a_step, b_step, g_step;
  logic [RAMP_W-1:0] frames_left;

  coef_t x, z1, z2, y1, y2, t, res;
  prod_t p;
  coef_t mul_a, mul_b, p_rnd;
  logic [AW-1:0] addr;

  logic [AW+CH_W-1:0] ch_ext;
  logic [AW-1:0]      in_addr;
  logic               in_range;
  logic               accept;
  logic               mem_wr;
  state_pair_t        rd_pair, wr_pair;

  assign ch_ext   = {{AW{1'b0}}, channel};
  assign in_addr  = ch_ext[AW-1:0];
  assign in_range = ch_ext < CH_LIMIT;
  assign accept   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign p_rnd    = round_q28(p);

  // near value in the upper half, far value in the lower half
  assign wr_pair = {y2, qadd(z1, p_rnd)};

  peq_state_mem #(.CHANNELS(CHANNELS)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (rd_pair),
    .wr_en   (mem_wr),
    .wr_addr (addr),
    .wr_data (wr_pair)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_wr     = 1'b0;
    mul_a      = coef_b;
    mul_b      = z2;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = in_range ? ST_LOAD : ST_OUT;
        end
      end
      ST_LOAD: state_next = ST_BZ2;
      ST_BZ2: begin
        mul_a      = coef_b;
        mul_b      = z2;
        state_next = ST_AZ1;
      end
      ST_AZ1: begin
        mul_a      = coef_a;
        mul_b      = z1;
        state_next = ST_BY1;
      end
      ST_BY1: begin
        mul_a      = coef_b;
        mul_b      = y1;
        state_next = ST_AY2;
      end
      ST_AY2: begin
        mul_a      = coef_a;
        mul_b      = y2;
        state_next = ST_GT;
      end
      ST_GT: begin
        mul_a      = gain_term;
        mul_b      = t;
        mem_wr     = 1'b1;
        state_next = ST_RES;
      end
      ST_RES: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath; p always holds the previous cycle's product
  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
    if (accept) begin
      x    <= {{(COEF_W-SAMPLE_W-5){sample_in[SAMPLE_W-1]}}, sample_in, 5'b0};
      res  <= {{(COEF_W-SAMPLE_W-5){sample_in[SAMPLE_W-1]}}, sample_in, 5'b0};
      addr <= in_addr;
    end
    case (state)
      ST_LOAD: begin
        z1 <= rd_pair.near_val;
        z2 <= rd_pair.far_val;
      end
      ST_AZ1: y1  <= qsub(x, p_rnd);
      ST_BY1: y2  <= qsub(y1, p_rnd);
      ST_AY2: t   <= qsub(qadd(z2, p_rnd), x);
      ST_RES: res <= qsub(x, p_rnd);
      default: ;
    endcase
  end

  // coefficient registers, config loads and per-frame ramp
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a      <= '0;
      coef_b      <= '0;
      gain_term   <= '0;
      a_step      <= '0;
      b_step      <= '0;
      g_step      <= '0;
      frames_left <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_A_START: coef_a      <= cfg_data;
          REG_B_START: coef_b      <= cfg_data;
          REG_G_START: gain_term   <= cfg_data;
          REG_A_STEP:  a_step      <= cfg_data;
          REG_B_STEP:  b_step      <= cfg_data;
          REG_G_STEP:  g_step      <= cfg_data;
          REG_RAMP:    frames_left <= cfg_data[RAMP_W-1:0];
          default: ;
        endcase
      end
      if (accept && channel == '0 && frames_left != '0) begin
        coef_a      <= qadd(coef_a, a_step);
        coef_b      <= qadd(coef_b, b_step);
        gain_term   <= qadd(gain_term, g_step);
        frames_left <= frames_left - 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      sample_out <= to_sample(res);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/peq_checker.sv
`default_nettype none

module peq_checker
  import peq_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [SAMPLE_W-1:0] sample_out
);

  // a result waiting downstream must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("sample_out changed while stalled");

  // one word in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in flight");

  // a new result only comes from a word in flight
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(!in_ready))
    else $error("result appeared with no word in flight");

endmodule

bind parametric_eq_section_top peq_checker u_peq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);

`default_nettype wire
